// File: design/category_batch_counter_with_hold_macros.svh
// Assertion macros for the category batch counter.
// Included by category_batch_counter_with_hold, the module that carries concurrent assertions; depends on nothing.
`ifndef CATEGORY_BATCH_COUNTER_WITH_HOLD_MACROS_SVH
`define CATEGORY_BATCH_COUNTER_WITH_HOLD_MACROS_SVH
`ifndef ASSERT_OFF
`define CBC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("category batch counter assertion failed");
`define CBC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("category batch counter assertion failed");
`else
`define CBC_ASSERT(lbl, prop)
`define CBC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: design/cbc_pkg.sv
// Shared types and constants for the category batch counter.
// Used by every module of the block; depends on nothing.
package cbc_pkg;

  localparam int CODE_W    = 8;
  localparam int TIME_W    = 32;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int CNT_OUT_W = 3;
  localparam int NUM_CODES = 3;
  localparam int REG_IDX_W = 2;

  localparam logic [CMD_W-1:0] CMD_DETECT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_NONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_COUNTED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ROLLOVER = 2'd2;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_HOLD_DELAY  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_CODE_FIRST  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CODE_SECOND = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_CODE_THIRD  = 2'd3;

  localparam logic [TIME_W-1:0] HOLD_DELAY_RESET  = 32'd800;
  localparam logic [CODE_W-1:0] CODE_FIRST_RESET  = 8'd1;
  localparam logic [CODE_W-1:0] CODE_SECOND_RESET = 8'd2;
  localparam logic [CODE_W-1:0] CODE_THIRD_RESET  = 8'd3;

  typedef struct packed {
    logic [TIME_W-1:0]                hold_delay;
    logic [NUM_CODES-1:0][CODE_W-1:0] code;
  } cfg_t;

  typedef enum logic {
    MODE_MATCH,
    MODE_ELAPSED
  } unit_mode_t;

  typedef struct packed {
    unit_mode_t        mode;
    logic [CODE_W-1:0] code_a;
    logic [CODE_W-1:0] code_b;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] delay;
  } unit_req_t;

endpackage

// File: design/category_batch_counter_with_hold.sv
// A scanned item is checked in S_SCAN until the matching or expiring category is found, or up
// to the last category (NUM_CATEGORIES - 1), and its result is then registered in S_FINISH.
// Paused detections, clears and unknown commands skip the scan and go straight to S_FINISH.
// The scan checks one category per cycle through the shared compare unit. A new item is taken
// only in S_IDLE, once S_FINISH has registered the result (it waits on out_ready). Reset is
// synchronous, restores the register defaults, zero counts and holds; no clearing pass follows.
module category_batch_counter_with_hold #(
  parameter int NUM_CATEGORIES = 3,
  parameter int BATCH_LIMIT    = 5
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [cbc_pkg::CMD_W-1:0]         cmd,
  input  logic [cbc_pkg::CODE_W-1:0]        raw_code,
  input  logic [cbc_pkg::TIME_W-1:0]        time_ms,
  input  logic                              paused,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [cbc_pkg::STATUS_W-1:0]      status,
  output logic [cbc_pkg::CODE_W-1:0]        category_code,
  output logic [cbc_pkg::CNT_OUT_W-1:0]     count,
  output logic                              hold_started,
  output logic [cbc_pkg::TIME_W-1:0]        event_time,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cbc_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [cbc_pkg::TIME_W-1:0]        cfg_data
);

  `include "category_batch_counter_with_hold_macros.svh"

  localparam int IDX_W = (NUM_CATEGORIES > 1) ? $clog2(NUM_CATEGORIES) : 1;
  localparam int CNT_W = $clog2(BATCH_LIMIT + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CATEGORIES - 1);
  localparam logic [CNT_W-1:0] LIMIT    = CNT_W'(BATCH_LIMIT);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t                         state;
  logic [IDX_W-1:0]               scan_idx;
  logic [cbc_pkg::CMD_W-1:0]      cmd_q;
  logic [cbc_pkg::CODE_W-1:0]     code_q;
  logic [cbc_pkg::TIME_W-1:0]     time_q;

  logic [CNT_W-1:0]               batch_count [NUM_CATEGORIES];
  logic                           hold_active [NUM_CATEGORIES];
  logic [cbc_pkg::TIME_W-1:0]     hold_start  [NUM_CATEGORIES];

  logic [cbc_pkg::STATUS_W-1:0]   res_status;
  logic [cbc_pkg::CODE_W-1:0]     res_code;
  logic [CNT_W-1:0]               res_count;
  logic                           res_hs;

  cbc_pkg::cfg_t                  cfg;
  cbc_pkg::unit_req_t             unit_req;
  logic                           unit_hit;
  logic [cbc_pkg::CODE_W-1:0]     cur_code;
  logic                           code_ok;
  logic                           det_hit;
  logic                           tick_hit;
  logic [CNT_W-1:0]               cur_count;
  logic [CNT_W-1:0]               new_count;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  cbc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  always_comb begin
    cur_code = '0;
    code_ok  = 1'b0;
    for (int k = 0; k < cbc_pkg::NUM_CODES; k++) begin
      if (k < NUM_CATEGORIES && int'(scan_idx) == k) begin
        cur_code = cfg.code[k];
        code_ok  = 1'b1;
      end
    end
  end

  always_comb begin
    unit_req.mode   = (cmd_q == cbc_pkg::CMD_TICK) ? cbc_pkg::MODE_ELAPSED
                                                   : cbc_pkg::MODE_MATCH;
    unit_req.code_a = code_q;
    unit_req.code_b = cur_code;
    unit_req.now    = time_q;
    unit_req.start  = hold_start[scan_idx];
    unit_req.delay  = cfg.hold_delay;
  end

  cbc_unit u_unit (
    .req (unit_req),
    .hit (unit_hit)
  );

  assign det_hit   = unit_hit && code_ok;
  assign tick_hit  = unit_hit && hold_active[scan_idx];
  assign cur_count = batch_count[scan_idx];
  assign new_count = (cur_count < LIMIT) ? cur_count + CNT_W'(1) : LIMIT;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      scan_idx  <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_CATEGORIES; i++) begin
        batch_count[i] <= '0;
        hold_active[i] <= 1'b0;
        hold_start[i]  <= '0;
      end
    end else begin
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_q      <= cmd;
            code_q     <= raw_code;
            time_q     <= time_ms;
            scan_idx   <= '0;
            res_status <= (cmd == cbc_pkg::CMD_CLEAR) ? cbc_pkg::ST_CLEARED
                                                       : cbc_pkg::ST_NONE;
            res_code   <= '0;
            res_count  <= '0;
            res_hs     <= 1'b0;
            case (cmd)
              cbc_pkg::CMD_DETECT: state <= paused ? S_FINISH : S_SCAN;
              cbc_pkg::CMD_TICK:   state <= S_SCAN;
              cbc_pkg::CMD_CLEAR: begin
                for (int i = 0; i < NUM_CATEGORIES; i++) begin
                  batch_count[i] <= '0;
                  hold_active[i] <= 1'b0;
                  hold_start[i]  <= '0;
                end
                state <= S_FINISH;
              end
              default: state <= S_FINISH;
            endcase
          end
        end
        S_SCAN: begin
          if (cmd_q == cbc_pkg::CMD_DETECT && det_hit) begin
            if (!hold_active[scan_idx]) begin
              batch_count[scan_idx] <= new_count;
              res_status            <= cbc_pkg::ST_COUNTED;
              res_code              <= code_q;
              res_count             <= new_count;
              if (new_count == LIMIT) begin
                hold_active[scan_idx] <= 1'b1;
                hold_start[scan_idx]  <= time_q;
                res_hs                <= 1'b1;
              end
            end
            state <= S_FINISH;
          end else if (cmd_q == cbc_pkg::CMD_TICK && tick_hit) begin
            hold_active[scan_idx] <= 1'b0;
            batch_count[scan_idx] <= '0;
            res_status            <= cbc_pkg::ST_ROLLOVER;
            res_code              <= cur_code;
            res_count             <= '0;
            state                 <= S_FINISH;
          end else if (scan_idx == LAST_IDX) begin
            state <= S_FINISH;
          end else begin
            scan_idx <= scan_idx + IDX_W'(1);
          end
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            status        <= res_status;
            category_code <= res_code;
            count         <= cbc_pkg::CNT_OUT_W'(res_count);
            hold_started  <= res_hs;
            event_time    <= (res_status == cbc_pkg::ST_ROLLOVER) ? time_q : '0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CBC_ASSERT(a_one_at_a_time, (in_valid && in_ready) |=> !in_ready)
  `CBC_ASSERT(a_rollover_blank, (out_valid && status == cbc_pkg::ST_ROLLOVER) |-> (count == '0))
  `CBC_ASSERT(a_hs_only_counted, (out_valid && hold_started) |-> (status == cbc_pkg::ST_COUNTED))
  `CBC_ASSERT(a_hold_full, hold_active[scan_idx] |-> (batch_count[scan_idx] == LIMIT))
  `CBC_ASSERT(a_idx_range, scan_idx <= LAST_IDX)

endmodule

// File: design/cbc_cfg.sv
// Configuration register file: hold delay and the three category codes.
// Depends on cbc_pkg.
module cbc_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic [cbc_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [cbc_pkg::TIME_W-1:0]       cfg_data,
  output cbc_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_delay <= cbc_pkg::HOLD_DELAY_RESET;
      cfg.code[0]    <= cbc_pkg::CODE_FIRST_RESET;
      cfg.code[1]    <= cbc_pkg::CODE_SECOND_RESET;
      cfg.code[2]    <= cbc_pkg::CODE_THIRD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        cbc_pkg::REG_HOLD_DELAY:  cfg.hold_delay <= cfg_data;
        cbc_pkg::REG_CODE_FIRST:  cfg.code[0] <= cfg_data[cbc_pkg::CODE_W-1:0];
        cbc_pkg::REG_CODE_SECOND: cfg.code[1] <= cfg_data[cbc_pkg::CODE_W-1:0];
        cbc_pkg::REG_CODE_THIRD:  cfg.code[2] <= cfg_data[cbc_pkg::CODE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: design/cbc_unit.sv
// Shared compare unit: code equality or wrapping elapsed-time test.
// Depends on cbc_pkg.
module cbc_unit (
  input  cbc_pkg::unit_req_t req,
  output logic               hit
);

  logic [cbc_pkg::TIME_W-1:0] elapsed;

  assign elapsed = req.now - req.start;

  always_comb begin
    case (req.mode)
      cbc_pkg::MODE_MATCH:   hit = (req.code_a == req.code_b);
      cbc_pkg::MODE_ELAPSED: hit = (elapsed >= req.delay);
      default:               hit = 1'b0;
    endcase
  end

endmodule

// File: tb/sv/cbc_tb_pkg.sv
`timescale 1ns / 1ps
// Batch ledger for the category batch counter testbench: predicts the report of each
// accepted transaction and checks the DUT reports in order. Depends on cbc_pkg.
package cbc_tb_pkg;
  import cbc_pkg::*;

  localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
  localparam logic [CNT_OUT_W-1:0] BATCH_FULL = 3'd5;
  localparam int                   SHOWN_MISMATCHES = 10;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [CODE_W-1:0]    category_code;
    logic [CNT_OUT_W-1:0] count;
    logic                 hold_started;
    logic [TIME_W-1:0]    event_time;
  } batch_report_t;

  class batch_ledger;
    logic [TIME_W-1:0]    delay_ms;
    logic [CODE_W-1:0]    codes[NUM_CODES];
    logic [CNT_OUT_W-1:0] tally[NUM_CODES];
    logic                 held[NUM_CODES];
    logic [TIME_W-1:0]    held_since[NUM_CODES];
    batch_report_t        due_reports[$];
    int                   mismatches;

    function new();
      delay_ms   = HOLD_DELAY_RESET;
      codes[0]   = CODE_FIRST_RESET;
      codes[1]   = CODE_SECOND_RESET;
      codes[2]   = CODE_THIRD_RESET;
      mismatches = 0;
      clear_batches();
    endfunction

    function void clear_batches();
      for (int i = 0; i < NUM_CODES; i++) begin
        tally[i]      = '0;
        held[i]       = 1'b0;
        held_since[i] = '0;
      end
    endfunction

    function void set_register(logic [REG_IDX_W-1:0] idx, logic [TIME_W-1:0] data);
      case (idx)
        REG_HOLD_DELAY:  delay_ms = data;
        REG_CODE_FIRST:  codes[0] = data[CODE_W-1:0];
        REG_CODE_SECOND: codes[1] = data[CODE_W-1:0];
        REG_CODE_THIRD:  codes[2] = data[CODE_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_item(logic [CMD_W-1:0] op, logic [CODE_W-1:0] code,
                            logic [TIME_W-1:0] now, logic halt);
      batch_report_t     r;
      logic [TIME_W-1:0] elapsed;
      int                hit;
      r   = '0;
      hit = -1;
      if (op == CMD_DETECT) begin
        if (!halt) begin
          for (int i = 0; i < NUM_CODES; i++) begin
            if (hit < 0 && codes[i] == code) hit = i;
          end
        end
        if (hit >= 0 && !held[hit]) begin
          if (tally[hit] < BATCH_FULL) tally[hit] = tally[hit] + 3'd1;
          r.status        = ST_COUNTED;
          r.category_code = code;
          r.count         = tally[hit];
          if (tally[hit] == BATCH_FULL) begin
            held[hit]       = 1'b1;
            held_since[hit] = now;
            r.hold_started  = 1'b1;
          end
        end
      end else if (op == CMD_TICK) begin
        for (int i = 0; i < NUM_CODES; i++) begin
          elapsed = now - held_since[i];
          if (hit < 0 && held[i] && elapsed >= delay_ms) begin
            hit             = i;
            held[i]         = 1'b0;
            tally[i]        = '0;
            r.status        = ST_ROLLOVER;
            r.category_code = codes[i];
            r.event_time    = now;
          end
        end
      end else if (op == CMD_CLEAR) begin
        clear_batches();
        r.status = ST_CLEARED;
      end
      due_reports.push_back(r);
    endfunction

    function void check_report(batch_report_t got);
      batch_report_t want;
      if (due_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
          $display("[%0t] report with nothing expected: status=%0d code=%0d count=%0d ",
                   $time, got.status, got.category_code, got.count,
                   "hold=%0d time=%0h", got.hold_started, got.event_time);
        return;
      end
      want = due_reports.pop_front();
      if (got.status !== want.status || got.category_code !== want.category_code ||
          got.count !== want.count || got.hold_started !== want.hold_started ||
          got.event_time !== want.event_time) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
          $display("[%0t] report mismatch: expected status=%0d code=%0d count=%0d ",
                   $time, want.status, want.category_code, want.count,
                   "hold=%0d time=%0h; got status=%0d code=%0d count=%0d ",
                   want.hold_started, want.event_time,
                   got.status, got.category_code, got.count,
                   "hold=%0d time=%0h", got.hold_started, got.event_time);
      end
    endfunction
  endclass

endpackage

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top-level testbench for category_batch_counter_with_hold: drives transactions and
// register writes with random idling and checks reports with the ledger in cbc_tb_pkg.
module tb_top;
  import cbc_pkg::*;
  import cbc_tb_pkg::*;

  localparam int IDLE_PCT        = 26;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 12;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CMD_W-1:0]     cmd = CMD_DETECT;
  logic [CODE_W-1:0]    raw_code = '0;
  logic [TIME_W-1:0]    time_ms = '0;
  logic                 paused = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [STATUS_W-1:0]  status;
  logic [CODE_W-1:0]    category_code;
  logic [CNT_OUT_W-1:0] count;
  logic                 hold_started;
  logic [TIME_W-1:0]    event_time;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index = REG_HOLD_DELAY;
  logic [TIME_W-1:0]    cfg_data = '0;

  bit                   quiet = 1'b0;
  bit                   hold_off_req = 1'b0;
  logic [TIME_W-1:0]    clock_ms = '0;
  int                   cycle_count = 0;
  batch_ledger          ledger;

  category_batch_counter_with_hold u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .raw_code      (raw_code),
    .time_ms       (time_ms),
    .paused        (paused),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .category_code (category_code),
    .count         (count),
    .hold_started  (hold_started),
    .event_time    (event_time),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin : monitor
    batch_report_t seen;
    if (!rst) begin
      if (cfg_valid && cfg_ready) ledger.set_register(cfg_index, cfg_data);
      if (in_valid && in_ready) ledger.take_item(cmd, raw_code, time_ms, paused);
      if (out_valid && out_ready) begin
        seen = {status, category_code, count, hold_started, event_time};
        ledger.check_report(seen);
      end
    end
  end

  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** category_batch_counter_with_hold: FAILED **");
    $finish;
  end

  task automatic send_item(input logic [CMD_W-1:0] op, input logic [CODE_W-1:0] code,
                           input logic [TIME_W-1:0] now, input logic halt);
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= op;
    raw_code <= code;
    time_ms  <= now;
    paused   <= halt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [TIME_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [TIME_W-1:0] delay, input logic [TIME_W-1:0] c0,
                           input logic [TIME_W-1:0] c1, input logic [TIME_W-1:0] c2);
    write_reg(REG_HOLD_DELAY, delay);
    write_reg(REG_CODE_FIRST, c0);
    write_reg(REG_CODE_SECOND, c1);
    write_reg(REG_CODE_THIRD, c2);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (ledger.due_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_random(input int n, input int unsigned step_max);
    logic [CMD_W-1:0]  op;
    logic [CODE_W-1:0] code;
    logic              halt;
    int unsigned       r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 4) clock_ms = $urandom();
      else if (r < 7) clock_ms = clock_ms - 32'd1;
      else clock_ms = clock_ms + $urandom_range(0, step_max);
      r = $urandom_range(0, 99);
      if (r < 56) op = CMD_DETECT;
      else if (r < 95) op = CMD_TICK;
      else if (r < 97) op = CMD_UNUSED;
      else op = CMD_CLEAR;
      if ($urandom_range(0, 99) < 80) code = ledger.codes[$urandom_range(0, NUM_CODES - 1)];
      else code = CODE_W'($urandom_range(0, 255));
      halt = ($urandom_range(0, 99) < 8);
      send_item(op, code, clock_ms, halt);
    end
  endtask

  initial begin : stimulus
    int unsigned d;
    ledger = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_item(CMD_DETECT, 8'd1, 32'd10, 1'b1);
    send_item(CMD_DETECT, 8'd0, 32'd11, 1'b0);
    send_item(CMD_DETECT, 8'hFF, 32'd12, 1'b0);
    for (int k = 0; k < 5; k++) send_item(CMD_DETECT, 8'd1, 32'd100 + k, 1'b0);
    send_item(CMD_DETECT, 8'd1, 32'd105, 1'b0);
    for (int k = 0; k < 5; k++) send_item(CMD_DETECT, 8'd2, 32'hFFFF_FF00, 1'b0);
    send_item(CMD_TICK, 8'hFF, 32'd903, 1'b1);
    send_item(CMD_TICK, 8'd0, 32'd904, 1'b0);
    send_item(CMD_TICK, 8'd0, 32'd905, 1'b0);
    send_item(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF, 1'b1);
    for (int k = 0; k < 5; k++) send_item(CMD_DETECT, 8'd3, 32'd0, 1'b0);
    send_item(CMD_TICK, 8'd3, 32'hFFFF_FFFF, 1'b0);
    send_item(CMD_DETECT, 8'd3, 32'd1, 1'b0);
    send_item(CMD_CLEAR, 8'd3, 32'd2, 1'b0);
    send_item(CMD_DETECT, 8'd3, 32'd3, 1'b0);

    clock_ms = 32'd1000;
    run_random(170, 300);
    settle();

    configure(32'd0, 32'd10, 32'd20, 32'd30);
    run_random(170, 20);
    settle();

    configure(32'hFFFF_FFFF, 32'hA5A5_A5FF, 32'h5A5A_5AFF, 32'hFFFF_FFFF);
    for (int k = 0; k < 5; k++) send_item(CMD_DETECT, 8'hFF, 32'h1234_5678, 1'b0);
    send_item(CMD_TICK, 8'hFF, 32'h1234_5676, 1'b0);
    send_item(CMD_TICK, 8'hFF, 32'h1234_5677, 1'b0);
    run_random(170, 1000);
    settle();

    configure(32'd37, ($urandom() & 32'hFFFF_FF00), ($urandom() & 32'hFFFF_FF00) | 32'h80,
              32'h0000_007F);
    quiet = 1'b1;
    run_random(40, 20);
    hold_off_req = 1'b1;
    run_random(160, 20);
    quiet = 1'b0;
    settle();

    configure(32'd1000, 32'd5, 32'd5, 32'd9);
    clock_ms = 32'hFFFF_F000;
    run_random(170, 350);
    settle();

    d = $urandom_range(1, 300);
    configure(d, $urandom(), $urandom(), $urandom());
    run_random(170, d / 2 + 2);
    settle();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.due_reports.size() == 0) begin
      $display("** category_batch_counter_with_hold: PASSED **");
    end else begin
      $display("** category_batch_counter_with_hold: FAILED **");
    end
    $finish;
  end

endmodule
